// ----- rtl/nps_pkg.sv -----
// Shared types, codes and defaults for the NAND page command sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nps_pkg;

    // Default geometry of the flash device
    localparam int PAGE_BYTES_DEF     = 2048;
    localparam int BLOCK_BYTES_DEF    = 131072;
    localparam int ROW_ADDR_BYTES_DEF = 3;
    localparam int MAX_ROW_BYTES      = 4;

    // Depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Request codes on req_type
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_ERASE = 3'd2;
    localparam logic [2:0] REQ_DATA  = 3'd3;
    localparam logic [2:0] REQ_READY = 3'd4;

    // NAND command codes
    localparam logic [7:0] CMD_READ_SETUP  = 8'h00;
    localparam logic [7:0] CMD_READ_GO     = 8'h30;
    localparam logic [7:0] CMD_PROG_SETUP  = 8'h80;
    localparam logic [7:0] CMD_PROG_GO     = 8'h10;
    localparam logic [7:0] CMD_ERASE_SETUP = 8'h60;
    localparam logic [7:0] CMD_ERASE_GO    = 8'hD0;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_READ,
        OP_WRITE,
        OP_ERASE
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_DATA
    } phase_t;

    typedef enum logic [3:0] {
        KIND_SELECT   = 4'd0,
        KIND_CMD      = 4'd1,
        KIND_ADDR     = 4'd2,
        KIND_WDATA    = 4'd3,
        KIND_RDATA    = 4'd4,
        KIND_WAIT     = 4'd5,
        KIND_DESELECT = 4'd6,
        KIND_ERROR    = 4'd7,
        KIND_DONE     = 4'd8
    } kind_t;

    // Classified input events
    typedef enum logic [4:0] {
        EV_NONE,
        EV_ERR,
        EV_DONE,
        EV_RD_START,
        EV_RD_ZERO,
        EV_WR_START,
        EV_WR_ZERO,
        EV_ER_START,
        EV_RDATA,
        EV_RDATA_END,
        EV_RDATA_NEXT,
        EV_WDATA,
        EV_WDATA_END,
        EV_RD_READY,
        EV_WR_FINISH,
        EV_WR_NEXT,
        EV_ER_FINISH,
        EV_ER_NEXT
    } ev_t;

    // Beat slots of one job, in bus order
    localparam int SL_ERR    = 0;
    localparam int SL_DATA   = 1;
    localparam int SL_SEL    = 2;
    localparam int SL_CMDA   = 3;
    localparam int SL_COL0   = 4;
    localparam int SL_COL1   = 5;
    localparam int SL_ROW0   = 6;
    localparam int SL_CMDB   = SL_ROW0 + MAX_ROW_BYTES;
    localparam int SL_WAIT   = SL_CMDB + 1;
    localparam int SL_DESEL  = SL_WAIT + 1;
    localparam int SL_DONE   = SL_DESEL + 1;
    localparam int NUM_SLOTS = SL_DONE + 1;

    typedef logic [NUM_SLOTS-1:0] slots_t;

    // One job handed from front to back
    typedef struct packed {
        slots_t      slots;
        logic        data_rd;
        logic [7:0]  data_byte;
        logic [7:0]  cmd_a;
        logic [7:0]  cmd_b;
        logic [15:0] column;
        logic [31:0] row_addr;
    } desc_t;

    function automatic slots_t sbit(input int s);
        slots_t m;
        m    = '0;
        m[s] = 1'b1;
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nps_front.sv -----
// Front end: classifies each accepted item, keeps the operation state and
// builds at most one job per item for the back end. Depends on nps_pkg.
`default_nettype none

module nps_front
    import nps_pkg::*;
#(
    parameter int PAGE_BYTES     = PAGE_BYTES_DEF,
    parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
    parameter int ROW_ADDR_BYTES = ROW_ADDR_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  req_type,
    input  wire logic [31:0] address,
    input  wire logic [31:0] length,
    input  wire logic [7:0]  data_byte,
    output logic             job_valid,
    output desc_t            job
);

    localparam int COL_BITS        = $clog2(PAGE_BYTES);
    localparam int ROW_BITS        = 8 * ROW_ADDR_BYTES;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int PAGES_PER_BLOCK = BLOCK_BYTES / PAGE_BYTES;
    localparam int PAGE_SHIFT_C    = COL_BITS;

    function automatic slots_t row_slots(input int n);
        slots_t m;
        m = '0;
        for (int k = 0; k < MAX_ROW_BYTES; k++)
        begin
            if (k < n)
            begin
                m[SL_ROW0 + k] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam slots_t ROW_MASK = row_slots(ROW_ADDR_BYTES);
    localparam slots_t COL_MASK = sbit(SL_COL0) | sbit(SL_COL1);

    op_t                 op_reg,    op_next;
    phase_t              phase_reg, phase_next;
    logic [ROW_BITS-1:0] page_reg,  page_next;
    logic [COL_BITS-1:0] col_reg,   col_next;
    logic [31:0]         left_reg,  left_next;

    ev_t                 ev;
    logic [COL_BITS:0]   col_inc;
    logic                col_carry;
    logic                left_last;
    logic                is_start;
    logic [31:0]         addr_pages;
    logic [ROW_BITS-1:0] start_page;

    assign col_inc    = {1'b0, col_reg} + {{COL_BITS{1'b0}}, 1'b1};
    assign col_carry  = col_inc[COL_BITS];
    assign left_last  = (left_reg == 32'd1);
    assign is_start   = (req_type == REQ_READ) || (req_type == REQ_WRITE) ||
                        (req_type == REQ_ERASE);
    assign addr_pages = address >> PAGE_SHIFT_C;
    assign start_page = addr_pages[ROW_BITS-1:0];

    // Classify the incoming item against the current state
    always_comb
    begin
        ev = EV_NONE;
        if (is_start)
        begin
            if (op_reg != OP_IDLE)
            begin
                ev = EV_ERR;
            end
            else if (req_type == REQ_ERASE)
            begin
                if ((address[BLOCK_SHIFT-1:0] != '0) || (length[BLOCK_SHIFT-1:0] != '0))
                begin
                    ev = EV_ERR;
                end
                else if (length == 32'd0)
                begin
                    ev = EV_DONE;
                end
                else
                begin
                    ev = EV_ER_START;
                end
            end
            else if (req_type == REQ_READ)
            begin
                ev = (length == 32'd0) ? EV_RD_ZERO : EV_RD_START;
            end
            else
            begin
                ev = (length == 32'd0) ? EV_WR_ZERO : EV_WR_START;
            end
        end
        else if (req_type == REQ_DATA)
        begin
            if ((phase_reg == PH_DATA) && (op_reg == OP_READ))
            begin
                if (left_last)
                begin
                    ev = EV_RDATA_END;
                end
                else if (col_carry)
                begin
                    ev = EV_RDATA_NEXT;
                end
                else
                begin
                    ev = EV_RDATA;
                end
            end
            else if ((phase_reg == PH_DATA) && (op_reg == OP_WRITE))
            begin
                ev = (left_last || col_carry) ? EV_WDATA_END : EV_WDATA;
            end
        end
        else if ((req_type == REQ_READY) && (phase_reg == PH_WAIT))
        begin
            case (op_reg)
                OP_READ:  ev = EV_RD_READY;
                OP_WRITE: ev = (left_reg == 32'd0) ? EV_WR_FINISH : EV_WR_NEXT;
                OP_ERASE: ev = (left_reg <= 32'(BLOCK_BYTES)) ? EV_ER_FINISH : EV_ER_NEXT;
                default:  ev = EV_NONE;
            endcase
        end
    end

    // Next operation state
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        page_next  = page_reg;
        col_next   = col_reg;
        left_next  = left_reg;
        case (ev)
            EV_RD_START:
            begin
                op_next    = OP_READ;
                phase_next = PH_WAIT;
                page_next  = start_page;
                col_next   = address[COL_BITS-1:0];
                left_next  = length;
            end
            EV_RD_ZERO:
            begin
                op_next    = OP_IDLE;
                phase_next = PH_IDLE;
                page_next  = start_page;
                col_next   = address[COL_BITS-1:0];
                left_next  = length;
            end
            EV_WR_START:
            begin
                op_next    = OP_WRITE;
                phase_next = PH_DATA;
                page_next  = start_page;
                col_next   = address[COL_BITS-1:0];
                left_next  = length;
            end
            EV_WR_ZERO:
            begin
                op_next    = OP_WRITE;
                phase_next = PH_WAIT;
                page_next  = start_page;
                col_next   = address[COL_BITS-1:0];
                left_next  = length;
            end
            EV_ER_START:
            begin
                op_next    = OP_ERASE;
                phase_next = PH_WAIT;
                page_next  = start_page;
                col_next   = '0;
                left_next  = length;
            end
            EV_RDATA, EV_WDATA:
            begin
                col_next  = col_inc[COL_BITS-1:0];
                left_next = left_reg - 32'd1;
            end
            EV_RDATA_END:
            begin
                op_next    = OP_IDLE;
                phase_next = PH_IDLE;
                col_next   = col_inc[COL_BITS-1:0];
                left_next  = left_reg - 32'd1;
            end
            EV_RDATA_NEXT:
            begin
                phase_next = PH_WAIT;
                col_next   = '0;
                page_next  = page_reg + ROW_BITS'(1);
                left_next  = left_reg - 32'd1;
            end
            EV_WDATA_END:
            begin
                phase_next = PH_WAIT;
                col_next   = col_inc[COL_BITS-1:0];
                left_next  = left_reg - 32'd1;
            end
            EV_RD_READY:
            begin
                phase_next = PH_DATA;
            end
            EV_WR_FINISH:
            begin
                op_next    = OP_IDLE;
                phase_next = PH_IDLE;
            end
            EV_WR_NEXT:
            begin
                phase_next = PH_DATA;
                col_next   = '0;
                page_next  = page_reg + ROW_BITS'(1);
            end
            EV_ER_FINISH:
            begin
                op_next    = OP_IDLE;
                phase_next = PH_IDLE;
                left_next  = '0;
            end
            EV_ER_NEXT:
            begin
                left_next = left_reg - 32'(BLOCK_BYTES);
                page_next = page_reg + ROW_BITS'(PAGES_PER_BLOCK);
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    // Build the job for the back end
    always_comb
    begin
        job           = '0;
        job.data_rd   = (op_reg == OP_READ);
        job.data_byte = data_byte;
        job.column    = 16'(col_next);
        job.row_addr  = 32'(page_next);
        case (ev)
            EV_ERR:
            begin
                job.slots = sbit(SL_ERR);
            end
            EV_DONE:
            begin
                job.slots = sbit(SL_DONE);
            end
            EV_RD_START:
            begin
                job.slots = sbit(SL_SEL) | sbit(SL_CMDA) | COL_MASK | ROW_MASK |
                            sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_a = CMD_READ_SETUP;
                job.cmd_b = CMD_READ_GO;
            end
            EV_RD_ZERO:
            begin
                job.slots = sbit(SL_SEL) | sbit(SL_DESEL) | sbit(SL_DONE);
            end
            EV_WR_START:
            begin
                job.slots = sbit(SL_SEL) | sbit(SL_CMDA) | COL_MASK | ROW_MASK;
                job.cmd_a = CMD_PROG_SETUP;
            end
            EV_WR_ZERO:
            begin
                job.slots = sbit(SL_SEL) | sbit(SL_CMDA) | COL_MASK | ROW_MASK |
                            sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_a = CMD_PROG_SETUP;
                job.cmd_b = CMD_PROG_GO;
            end
            EV_ER_START:
            begin
                job.slots = sbit(SL_SEL) | sbit(SL_CMDA) | ROW_MASK |
                            sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_a = CMD_ERASE_SETUP;
                job.cmd_b = CMD_ERASE_GO;
            end
            EV_RDATA, EV_WDATA:
            begin
                job.slots = sbit(SL_DATA);
            end
            EV_RDATA_END:
            begin
                job.slots = sbit(SL_DATA) | sbit(SL_DESEL) | sbit(SL_DONE);
            end
            EV_RDATA_NEXT:
            begin
                job.slots = sbit(SL_DATA) | sbit(SL_CMDA) | COL_MASK | ROW_MASK |
                            sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_a = CMD_READ_SETUP;
                job.cmd_b = CMD_READ_GO;
            end
            EV_WDATA_END:
            begin
                job.slots = sbit(SL_DATA) | sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_b = CMD_PROG_GO;
            end
            EV_WR_FINISH, EV_ER_FINISH:
            begin
                job.slots = sbit(SL_DESEL) | sbit(SL_DONE);
            end
            EV_WR_NEXT:
            begin
                job.slots = sbit(SL_CMDA) | COL_MASK | ROW_MASK;
                job.cmd_a = CMD_PROG_SETUP;
            end
            EV_ER_NEXT:
            begin
                job.slots = sbit(SL_CMDA) | ROW_MASK | sbit(SL_CMDB) | sbit(SL_WAIT);
                job.cmd_a = CMD_ERASE_SETUP;
                job.cmd_b = CMD_ERASE_GO;
            end
            default:
            begin
                job.slots = '0;
            end
        endcase
    end

    assign job_valid = accept && (job.slots != '0);

    // Hold state until an item is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            phase_reg <= PH_IDLE;
            page_reg  <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            page_reg  <= page_next;
            col_reg   <= col_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nps_queue.sv -----
// Short job queue between the front and back ends of the sequencer.
// Depends on nps_pkg for the job type and depth.
`default_nettype none

module nps_queue
    import nps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire desc_t wr_data,
    input  wire logic  rd_en,
    output desc_t      rd_data,
    output logic       not_empty,
    output logic       full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    desc_t             store_reg [QUEUE_DEPTH];
    logic [PTR_BITS:0] wr_ptr_reg;
    logic [PTR_BITS:0] rd_ptr_reg;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[PTR_BITS] != rd_ptr_reg[PTR_BITS]) &&
                       (wr_ptr_reg[PTR_BITS-1:0] == rd_ptr_reg[PTR_BITS-1:0]);
    assign rd_data   = store_reg[rd_ptr_reg[PTR_BITS-1:0]];

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the job
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg[PTR_BITS-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nps_back.sv -----
// Back end: walks the beat slots of each job in bus order and presents one
// result beat at a time through an output register. Depends on nps_pkg.
`default_nettype none

module nps_back
    import nps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire desc_t      q_data,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output logic [3:0]      cycle_kind,
    output logic [7:0]      value,
    output logic            last
);

    slots_t      mask_reg;
    desc_t       desc_reg;
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_value_reg;
    logic        out_last_reg;

    logic        use_head;
    slots_t      cur_mask;
    desc_t       cur_desc;
    slots_t      pick;
    slots_t      rest;
    logic        fire;
    kind_t       beat_kind;
    logic [7:0]  beat_value;

    assign use_head = (mask_reg == '0);
    assign cur_mask = use_head ? (q_valid ? q_data.slots : '0) : mask_reg;
    assign cur_desc = use_head ? q_data : desc_reg;
    assign pick     = cur_mask & (~cur_mask + 1'b1);
    assign rest     = cur_mask & ~pick;
    assign fire     = (!out_valid_reg || pop) && (cur_mask != '0);
    assign q_pop    = fire && use_head;

    // Decode the chosen slot into a beat
    always_comb
    begin
        beat_kind  = KIND_SELECT;
        beat_value = 8'h00;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (pick[s])
            begin
                case (s)
                    SL_ERR:   beat_kind = KIND_ERROR;
                    SL_DATA:
                    begin
                        beat_kind  = cur_desc.data_rd ? KIND_RDATA : KIND_WDATA;
                        beat_value = cur_desc.data_byte;
                    end
                    SL_SEL:   beat_kind = KIND_SELECT;
                    SL_CMDA:
                    begin
                        beat_kind  = KIND_CMD;
                        beat_value = cur_desc.cmd_a;
                    end
                    SL_COL0:
                    begin
                        beat_kind  = KIND_ADDR;
                        beat_value = cur_desc.column[7:0];
                    end
                    SL_COL1:
                    begin
                        beat_kind  = KIND_ADDR;
                        beat_value = cur_desc.column[15:8];
                    end
                    SL_CMDB:
                    begin
                        beat_kind  = KIND_CMD;
                        beat_value = cur_desc.cmd_b;
                    end
                    SL_WAIT:  beat_kind = KIND_WAIT;
                    SL_DESEL: beat_kind = KIND_DESELECT;
                    SL_DONE:  beat_kind = KIND_DONE;
                    default:
                    begin
                        // row address bytes, low byte first
                        beat_kind  = KIND_ADDR;
                        beat_value = cur_desc.row_addr[8 * (s - SL_ROW0) +: 8];
                    end
                endcase
            end
        end
    end

    // Advance through the slots and hold the output beat until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mask_reg      <= rest;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the job and beat payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_data;
        end
        if (fire)
        begin
            out_kind_reg  <= beat_kind;
            out_value_reg <= beat_value;
            out_last_reg  <= (rest == '0);
        end
    end

    assign empty      = !out_valid_reg;
    assign cycle_kind = out_kind_reg;
    assign value      = out_value_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/nand_page_command_sequencer.sv -----
// Top level of the large-page NAND command sequencer: front end, job queue
// and back end. Depends on nps_pkg, nps_front, nps_queue and nps_back.
`default_nettype none

// Requests, data bytes and ready events enter through a queue-style push/full
// port; every item is taken while full is low and, when it gives any beat,
// turned into one job held in a four-entry queue, and full rises only while
// that queue is full. The first beat of a job passes through the queue entry
// and then the output register before it reaches the result ports. The back
// end emits one bus-cycle beat per cycle, while its output is empty or popped,
// from a single output register: a streamed data byte gives one beat, a start
// or a page or block crossing up to ten (select or data byte, command, two
// column bytes, up to four row bytes, command, wait), and that beat rate sets
// the sustained throughput. The last flag marks the final beat of each item;
// items that give no beat (ready during a read wait, stray bytes or events)
// leave no trace. Page and block sizes must be powers of two.
module nand_page_command_sequencer
    import nps_pkg::*;
#(
    parameter int PAGE_BYTES     = PAGE_BYTES_DEF,
    parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
    parameter int ROW_ADDR_BYTES = ROW_ADDR_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [31:0] address,
    input  wire logic [31:0] length,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       cycle_kind,
    output logic [7:0]       value,
    output logic             last
);

    logic  accept;
    logic  job_valid;
    desc_t job;
    desc_t head;
    logic  head_valid;
    logic  head_pop;

    assign accept = push && !full;

    nps_front #(
        .PAGE_BYTES     (PAGE_BYTES),
        .BLOCK_BYTES    (BLOCK_BYTES),
        .ROW_ADDR_BYTES (ROW_ADDR_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .address   (address),
        .length    (length),
        .data_byte (data_byte),
        .job_valid (job_valid),
        .job       (job)
    );

    nps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_valid),
        .wr_data   (job),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (head_valid),
        .full      (full)
    );

    nps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (head_valid),
        .q_data     (head),
        .q_pop      (head_pop),
        .pop        (pop),
        .empty      (empty),
        .cycle_kind (cycle_kind),
        .value      (value),
        .last       (last)
    );

endmodule

`default_nettype wire

// ----- rtl/nps_checker.sv -----
// Port-level checks for the NAND page command sequencer, bound to the top
// level. Depends on nps_pkg for the beat kinds.
`default_nettype none

module nps_checker
    import nps_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic [2:0]  req_type,
    input wire logic [31:0] address,
    input wire logic [31:0] length,
    input wire logic [7:0]  data_byte,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  cycle_kind,
    input wire logic [7:0]  value,
    input wire logic        last
);

    // A waiting beat holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cycle_kind) && $stable(value) &&
                              $stable(last)))
        else $error("result beat changed while waiting");

    // Control beats carry a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (cycle_kind == KIND_SELECT || cycle_kind == KIND_WAIT ||
                    cycle_kind == KIND_DESELECT || cycle_kind == KIND_ERROR ||
                    cycle_kind == KIND_DONE)) |-> (value == 8'h00))
        else $error("control beat with non-zero value");

    // Error and done always close an item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (cycle_kind == KIND_ERROR || cycle_kind == KIND_DONE)) |-> last)
        else $error("error or done beat without last");

    // Select and commands are always followed by more beats of the same item
    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (cycle_kind == KIND_SELECT || cycle_kind == KIND_CMD)) |-> !last)
        else $error("select or command beat marked last");

endmodule

bind nand_page_command_sequencer nps_checker u_nps_checker (.*);

`default_nettype wire
